@@ rtl/core/lmhp_pkg.sv @@
package lmhp_pkg;

  typedef logic [2:0] status_t;
  typedef logic [2:0] mtype_t;
  typedef logic [4:0] pos_t;

  localparam status_t ST_TOO_SHORT   = 3'd0;
  localparam status_t ST_JOIN_REQ    = 3'd1;
  localparam status_t ST_UP_PORT     = 3'd2;
  localparam status_t ST_UP_NO_PORT  = 3'd3;
  localparam status_t ST_HEADER_ONLY = 3'd4;

  localparam mtype_t MTYPE_JOIN_REQ  = 3'd0;
  localparam mtype_t MTYPE_UNCONF_UP = 3'd2;
  localparam mtype_t MTYPE_CONF_UP   = 3'd4;

  // Octet positions of the frame layout
  localparam pos_t POS_MHDR      = 5'd0;
  localparam pos_t POS_FCTRL     = 5'd5;
  localparam pos_t POS_FCNT_LO   = 5'd6;
  localparam pos_t POS_FCNT_HI   = 5'd7;
  localparam pos_t POS_FPORT     = 5'd8;
  localparam pos_t POS_EUI1_BASE = 5'd1;
  localparam pos_t POS_EUI2_BASE = 5'd9;
  localparam pos_t POS_NONCE_LO  = 5'd17;
  localparam pos_t POS_NONCE_HI  = 5'd18;
  localparam pos_t POS_MAX       = 5'd31;

  // Last-octet positions that make a frame long enough
  localparam pos_t POS_MIN_LAST  = 5'd3;
  localparam pos_t POS_UP_LAST   = 5'd7;
  localparam pos_t POS_JOIN_LAST = 5'd18;

  function automatic logic is_uplink(input mtype_t mt);
    is_uplink = (mt == MTYPE_UNCONF_UP) || (mt == MTYPE_CONF_UP);
  endfunction

endpackage

@@ rtl/core/lorawan_mac_header_parser_unit.sv @@
// A result appears in out_* in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the byte position compare and the field
// capture sit between the frame state registers and the result register.
// in_ready falls only while a result waits in the result register unaccepted.
// Reset (rst_n low, synchronous) clears the frame state and the result valid.
module lorawan_mac_header_parser_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_frame_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lmhp_pkg::status_t     out_status,
  output lmhp_pkg::mtype_t      out_message_type,
  output logic [1:0]            out_major_rev,
  output logic [63:0]           out_join_eui,
  output logic [63:0]           out_device_eui,
  output logic [15:0]           out_device_nonce,
  output logic [31:0]           out_device_address,
  output logic [7:0]            out_frame_control,
  output logic                  out_adr_flag,
  output logic                  out_ack_flag,
  output logic [15:0]           out_frame_counter,
  output logic [7:0]            out_frame_port
);
  import lmhp_pkg::*;

  pos_t        pos_r, pos_nxt;
  logic [7:0]  hdr_r, hdr_nxt, hdr_cap;
  logic [63:0] eui1_r, eui1_nxt, eui1_cap;
  logic [63:0] eui2_r, eui2_nxt, eui2_cap;
  logic [15:0] nonce_r, nonce_nxt, nonce_cap;
  logic [7:0]  ctl_r, ctl_nxt, ctl_cap;
  logic [15:0] cnt_r, cnt_nxt, cnt_cap;
  logic [7:0]  port_r, port_nxt, port_cap;
  logic        port_seen_r, port_seen_nxt, port_seen_cap;
  logic        out_valid_r, out_valid_nxt;

  status_t     st_r, st_nxt;
  mtype_t      mt_r, mt_nxt;
  logic [1:0]  major_r, major_nxt;
  logic [63:0] join_eui_r, join_eui_nxt;
  logic [63:0] dev_eui_r, dev_eui_nxt;
  logic [15:0] nonce_res_r, nonce_res_nxt;
  logic [31:0] dev_addr_r, dev_addr_nxt;
  logic [7:0]  fctrl_r, fctrl_nxt;
  logic        adr_r, adr_nxt;
  logic        ack_r, ack_nxt;
  logic [15:0] fcnt_r, fcnt_nxt;
  logic [7:0]  fport_r, fport_nxt;

  logic        in_fire;
  logic        res_load;
  mtype_t      mt_cap;
  pos_t        port_pos;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign res_load = in_fire && in_last_byte;

  // Capture the current beat at the current position
  always_comb begin
    hdr_cap   = hdr_r;
    eui1_cap  = eui1_r;
    eui2_cap  = eui2_r;
    nonce_cap = nonce_r;
    ctl_cap   = ctl_r;
    cnt_cap   = cnt_r;
    if (pos_r == POS_MHDR) begin
      hdr_cap = in_frame_byte;
    end
    for (int i = 0; i < 8; i++) begin
      if (pos_r == POS_EUI1_BASE + 5'(i)) begin
        eui1_cap[8*i +: 8] = eui1_r[8*i +: 8] | in_frame_byte;
      end
      if (pos_r == POS_EUI2_BASE + 5'(i)) begin
        eui2_cap[8*i +: 8] = eui2_r[8*i +: 8] | in_frame_byte;
      end
    end
    if (pos_r == POS_NONCE_LO) begin
      nonce_cap[7:0] = nonce_r[7:0] | in_frame_byte;
    end
    if (pos_r == POS_NONCE_HI) begin
      nonce_cap[15:8] = nonce_r[15:8] | in_frame_byte;
    end
    if (pos_r == POS_FCTRL) begin
      ctl_cap = in_frame_byte;
    end
    if (pos_r == POS_FCNT_LO) begin
      cnt_cap[7:0] = cnt_r[7:0] | in_frame_byte;
    end
    if (pos_r == POS_FCNT_HI) begin
      cnt_cap[15:8] = cnt_r[15:8] | in_frame_byte;
    end
  end

  assign mt_cap   = hdr_cap[7:5];
  assign port_pos = POS_FPORT + {1'b0, ctl_cap[3:0]};

  always_comb begin
    port_cap      = port_r;
    port_seen_cap = port_seen_r;
    if (pos_r != POS_MHDR && is_uplink(mt_cap) && !port_seen_r && pos_r == port_pos) begin
      port_cap      = in_frame_byte;
      port_seen_cap = 1'b1;
    end
  end

  // Advance on every beat; drop the whole frame state after the last one
  always_comb begin
    pos_nxt       = pos_r;
    hdr_nxt       = hdr_r;
    eui1_nxt      = eui1_r;
    eui2_nxt      = eui2_r;
    nonce_nxt     = nonce_r;
    ctl_nxt       = ctl_r;
    cnt_nxt       = cnt_r;
    port_nxt      = port_r;
    port_seen_nxt = port_seen_r;
    if (in_fire) begin
      if (in_last_byte) begin
        pos_nxt       = '0;
        hdr_nxt       = '0;
        eui1_nxt      = '0;
        eui2_nxt      = '0;
        nonce_nxt     = '0;
        ctl_nxt       = '0;
        cnt_nxt       = '0;
        port_nxt      = '0;
        port_seen_nxt = 1'b0;
      end else begin
        pos_nxt       = (pos_r == POS_MAX) ? pos_r : pos_r + 5'd1;
        hdr_nxt       = hdr_cap;
        eui1_nxt      = eui1_cap;
        eui2_nxt      = eui2_cap;
        nonce_nxt     = nonce_cap;
        ctl_nxt       = ctl_cap;
        cnt_nxt       = cnt_cap;
        port_nxt      = port_cap;
        port_seen_nxt = port_seen_cap;
      end
    end
  end

  // Classify the frame from the captured fields
  always_comb begin
    st_nxt        = ST_TOO_SHORT;
    mt_nxt        = '0;
    major_nxt     = '0;
    join_eui_nxt  = '0;
    dev_eui_nxt   = '0;
    nonce_res_nxt = '0;
    dev_addr_nxt  = '0;
    fctrl_nxt     = '0;
    adr_nxt       = 1'b0;
    ack_nxt       = 1'b0;
    fcnt_nxt      = '0;
    fport_nxt     = '0;
    if (pos_r >= POS_MIN_LAST) begin
      mt_nxt    = mt_cap;
      major_nxt = hdr_cap[1:0];
      if (mt_cap == MTYPE_JOIN_REQ && pos_r >= POS_JOIN_LAST) begin
        st_nxt        = ST_JOIN_REQ;
        join_eui_nxt  = eui1_cap;
        dev_eui_nxt   = eui2_cap;
        nonce_res_nxt = nonce_cap;
      end else if (is_uplink(mt_cap) && pos_r >= POS_UP_LAST) begin
        st_nxt       = port_seen_cap ? ST_UP_PORT : ST_UP_NO_PORT;
        dev_addr_nxt = eui1_cap[31:0];
        fctrl_nxt    = ctl_cap;
        adr_nxt      = ctl_cap[7];
        ack_nxt      = ctl_cap[5];
        fcnt_nxt     = cnt_cap;
        fport_nxt    = port_seen_cap ? port_cap : 8'd0;
      end else begin
        st_nxt = ST_HEADER_ONLY;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hdr_r       <= '0;
      eui1_r      <= '0;
      eui2_r      <= '0;
      nonce_r     <= '0;
      ctl_r       <= '0;
      cnt_r       <= '0;
      port_r      <= '0;
      port_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      hdr_r       <= hdr_nxt;
      eui1_r      <= eui1_nxt;
      eui2_r      <= eui2_nxt;
      nonce_r     <= nonce_nxt;
      ctl_r       <= ctl_nxt;
      cnt_r       <= cnt_nxt;
      port_r      <= port_nxt;
      port_seen_r <= port_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      st_r        <= st_nxt;
      mt_r        <= mt_nxt;
      major_r     <= major_nxt;
      join_eui_r  <= join_eui_nxt;
      dev_eui_r   <= dev_eui_nxt;
      nonce_res_r <= nonce_res_nxt;
      dev_addr_r  <= dev_addr_nxt;
      fctrl_r     <= fctrl_nxt;
      adr_r       <= adr_nxt;
      ack_r       <= ack_nxt;
      fcnt_r      <= fcnt_nxt;
      fport_r     <= fport_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = st_r;
  assign out_message_type   = mt_r;
  assign out_major_rev      = major_r;
  assign out_join_eui       = join_eui_r;
  assign out_device_eui     = dev_eui_r;
  assign out_device_nonce   = nonce_res_r;
  assign out_device_address = dev_addr_r;
  assign out_frame_control  = fctrl_r;
  assign out_adr_flag       = adr_r;
  assign out_ack_flag       = ack_r;
  assign out_frame_counter  = fcnt_r;
  assign out_frame_port     = fport_r;

`ifndef SYNTH
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while a result is stalled");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> pos_r == POS_MHDR && !port_seen_r && out_valid_r)
    else $error("frame state not cleared after last beat");

  a_port_only_uplink: assert property (@(posedge clk) disable iff (!rst_n)
    port_seen_r |-> is_uplink(hdr_r[7:5]))
    else $error("port captured for a non-uplink frame");

  a_short_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r == ST_TOO_SHORT |-> mt_r == '0 && major_r == '0)
    else $error("too-short result carries header fields");

  a_join_fields_only_join: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r != ST_JOIN_REQ |-> join_eui_r == '0 && nonce_res_r == '0)
    else $error("join fields set on a non-join result");
`endif

endmodule
